### hdl/stsdp_pkg.sv
`default_nettype none
package stsdp_pkg;

  localparam int SCORE_W      = 32;
  localparam int POS_BITS     = 12;
  localparam int CLU_W        = 4;
  localparam int CNT_W        = 5;
  localparam int MAX_CLUSTERS = 16;
  localparam int CFG_W        = 5;

  localparam logic signed [SCORE_W-1:0] SAT_HI = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SAT_LO = {1'b1, {(SCORE_W-1){1'b0}}};

  typedef enum logic [0:0] {
    REG_NUM_CLUSTERS,
    REG_TIE_LAST
  } cfg_reg_t;

  // How a start's candidate total is formed
  typedef enum logic [2:0] {
    K_ROW1,   // first row: total is the score itself
    K_FIRST,  // start zero: candidate is the score, always taken
    K_ALONE,  // single cluster, start above zero: most negative value
    K_ROW0,   // start one: previous row is the fixed zero row
    K_PRIOR   // best other-cluster total of a stored row plus the score
  } cand_kind_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      start_sequence;
  } item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]       position;
    logic [CLU_W-1:0]          cluster;
    logic signed [SCORE_W-1:0] total_score;
    logic [POS_BITS-1:0]       best_start;
  } result_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [POS_BITS-1:0]       position;
    logic [CLU_W-1:0]          cluster;
    logic [POS_BITS-1:0]       start;
    cand_kind_t                kind;
    logic                      emit;
  } stage_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] best;
    logic signed [SCORE_W-1:0] second;
    logic [CLU_W-1:0]          best_cluster;
  } row_sum_t;

  typedef struct packed {
    logic                      valid;
    logic [POS_BITS-1:0]       position;
    logic [CLU_W-1:0]          cluster;
    logic signed [SCORE_W-1:0] total;
  } rec_t;

endpackage
`default_nettype wire

### hdl/segment_total_score_dp.sv
`default_nettype none
// Segmentation total-score engine. One score beat is taken per clock unless stalled; a
// beat that closes the starts of a (position, cluster) pair gives one result beat, via
// the score stage and result register; the other beats give none. Each beat reads one
// row summary (best total, its cluster, second best) from a single memory of MAX_POSITIONS
// rows with one read and one write port; the read is issued as the beat is taken and the
// summary of a finished row is written before any later row can read it. Row zero is a
// fixed zero row and is not stored, and rows are rewritten from cluster zero in every
// sequence, so there is no clearing pass after reset. item_stall rises only while the
// result register holds a stalled beat and the beat in the score stage has a result of
// its own. Write num_clusters and tie_last only while no beat is in flight.
module segment_total_score_dp #(
  parameter int MAX_POSITIONS = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire stsdp_pkg::item_t             item,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output stsdp_pkg::result_t                result,
  input  wire logic                         cfg_write,
  input  wire stsdp_pkg::cfg_reg_t          cfg_index,
  input  wire logic [stsdp_pkg::CFG_W-1:0]  cfg_data
);
  import stsdp_pkg::*;

  localparam int PosW = $clog2(MAX_POSITIONS);

  logic [CFG_W-1:0] num_clusters;
  logic             tie_last;
  logic             accept, live, load;
  logic [PosW-1:0]  rd_addr;
  stage_t           stage;
  row_sum_t         rd_data;
  rec_t             rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= CFG_W'(2);
      tie_last     <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NUM_CLUSTERS: num_clusters <= cfg_data;
        REG_TIE_LAST:     tie_last     <= cfg_data[0];
      endcase
    end
  end

  assign accept = item_valid && !item_stall;
  assign load   = accept && live;

  stsdp_seq #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .num_clusters (num_clusters),
    .stage        (stage),
    .live         (live),
    .rd_addr      (rd_addr)
  );

  stsdp_row_store #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_row_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rec     (rec),
    .rd_data (rd_data)
  );

  stsdp_score u_score (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .stage        (stage),
    .rd_data      (rd_data),
    .tie_last     (tie_last),
    .result_stall (result_stall),
    .hold         (item_stall),
    .result_valid (result_valid),
    .result       (result),
    .rec          (rec)
  );

  // The winning start never lies beyond the end position
  a_start_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.best_start <= result.position))
    else $error("best_start beyond position");

  // A row-summary write always follows a freshly loaded result beat
  a_rec_with_result: assert property (@(posedge clk) disable iff (rst)
    rec.valid |-> result_valid)
    else $error("row summary written without a result");

  // Input backpressure only comes from a stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while result path free");

endmodule
`default_nettype wire

### hdl/stsdp_seq.sv
`default_nettype none
module stsdp_seq #(
  parameter int MAX_POSITIONS = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               accept,
  input  wire stsdp_pkg::item_t                   item,
  input  wire logic [stsdp_pkg::CFG_W-1:0]        num_clusters,
  output stsdp_pkg::stage_t                       stage,
  output logic                                    live,
  output logic [$clog2(MAX_POSITIONS)-1:0]        rd_addr
);
  import stsdp_pkg::*;

  localparam int PosW = $clog2(MAX_POSITIONS);

  logic [PosW-1:0]  pos, pos_e, pos_next;
  logic [PosW-1:0]  start, start_e, start_next;
  logic [CLU_W-1:0] clu, clu_e, clu_next;
  logic             done, done_e, done_next;
  logic [CNT_W-1:0] nc;
  logic             row1, emit, last_clu;

  always_comb begin
    if (item.start_sequence) begin
      pos_e   = PosW'(1);
      start_e = '0;
      clu_e   = '0;
      done_e  = 1'b0;
    end else begin
      pos_e   = pos;
      start_e = start;
      clu_e   = clu;
      done_e  = done;
    end
  end

  always_comb begin
    if (num_clusters == '0) begin
      nc = CNT_W'(1);
    end else if (num_clusters > CNT_W'(MAX_CLUSTERS)) begin
      nc = CNT_W'(MAX_CLUSTERS);
    end else begin
      nc = num_clusters;
    end
  end

  assign row1     = (pos_e == PosW'(1));
  assign emit     = row1 || (({1'b0, start_e} + (PosW+1)'(2)) >= {1'b0, pos_e});
  assign last_clu = ({1'b0, clu_e} + CNT_W'(1)) >= nc;
  assign live     = !done_e;
  assign rd_addr  = start_e - PosW'(1);

  always_comb begin
    stage.score    = item.score;
    stage.position = POS_BITS'(pos_e);
    stage.cluster  = clu_e;
    stage.start    = POS_BITS'(start_e);
    stage.emit     = emit;
    priority if (row1) begin
      stage.kind = K_ROW1;
    end else if (start_e == '0) begin
      stage.kind = K_FIRST;
    end else if (nc <= CNT_W'(1)) begin
      stage.kind = K_ALONE;
    end else if (start_e == PosW'(1)) begin
      stage.kind = K_ROW0;
    end else begin
      stage.kind = K_PRIOR;
    end
  end

  always_comb begin
    pos_next   = pos_e;
    start_next = start_e;
    clu_next   = clu_e;
    done_next  = done_e;
    if (!done_e) begin
      if (emit) begin
        start_next = '0;
        if (last_clu) begin
          clu_next = '0;
          pos_next = pos_e + PosW'(1);
          if (pos_e == PosW'(MAX_POSITIONS - 1)) begin
            done_next = 1'b1;
          end
        end else begin
          clu_next = clu_e + CLU_W'(1);
        end
      end else begin
        start_next = start_e + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= PosW'(1);
      start <= '0;
      clu   <= '0;
      done  <= 1'b0;
    end else if (accept) begin
      pos   <= pos_next;
      start <= start_next;
      clu   <= clu_next;
      done  <= done_next;
    end
  end

endmodule
`default_nettype wire

### hdl/stsdp_row_store.sv
`default_nettype none
module stsdp_row_store #(
  parameter int MAX_POSITIONS = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rd_en,
  input  wire logic [$clog2(MAX_POSITIONS)-1:0]   rd_addr,
  input  wire stsdp_pkg::rec_t                    rec,
  output stsdp_pkg::row_sum_t                     rd_data
);
  import stsdp_pkg::*;

  localparam int PosW = $clog2(MAX_POSITIONS);

  row_sum_t mem [MAX_POSITIONS];
  row_sum_t acc, acc_next;

  // Summary of the row being built; cluster zero opens a fresh row
  always_comb begin
    acc_next = acc;
    if (rec.cluster == '0) begin
      acc_next.best         = rec.total;
      acc_next.second       = SAT_LO;
      acc_next.best_cluster = '0;
    end else if (rec.total > acc.best) begin
      acc_next.second       = acc.best;
      acc_next.best         = rec.total;
      acc_next.best_cluster = rec.cluster;
    end else if (rec.total > acc.second) begin
      acc_next.second = rec.total;
    end
  end

  always_ff @(posedge clk) begin
    if (rec.valid) begin
      acc                         <= acc_next;
      mem[PosW'(rec.position)]    <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hdl/stsdp_score.sv
`default_nettype none
module stsdp_score (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire stsdp_pkg::stage_t    stage,
  input  wire stsdp_pkg::row_sum_t  rd_data,
  input  wire logic                 tie_last,
  input  wire logic                 result_stall,
  output logic                      hold,
  output logic                      result_valid,
  output stsdp_pkg::result_t        result,
  output stsdp_pkg::rec_t           rec
);
  import stsdp_pkg::*;

  stage_t                    s1;
  logic                      s1_valid, s1_go, out_free;
  logic signed [SCORE_W-1:0] other, cand, rmax, total;
  logic signed [SCORE_W:0]   sum;
  logic [POS_BITS-1:0]       rstart, kstart;
  logic                      take;

  assign out_free = !result_valid || !result_stall;
  assign s1_go    = s1_valid && (!s1.emit || out_free);
  assign hold     = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= stage;
    end
  end

  always_comb begin
    if (s1.kind == K_ROW0) begin
      other = '0;
    end else if (rd_data.best_cluster == s1.cluster) begin
      other = rd_data.second;
    end else begin
      other = rd_data.best;
    end
  end

  assign sum = {other[SCORE_W-1], other} + {s1.score[SCORE_W-1], s1.score};

  always_comb begin
    unique case (s1.kind)
      K_ROW1, K_FIRST: cand = s1.score;
      K_ALONE:         cand = SAT_LO;
      K_ROW0, K_PRIOR: begin
        if (sum[SCORE_W] != sum[SCORE_W-1]) begin
          cand = sum[SCORE_W] ? SAT_LO : SAT_HI;
        end else begin
          cand = sum[SCORE_W-1:0];
        end
      end
      default:         cand = s1.score;
    endcase
  end

  assign take = (s1.kind == K_FIRST) || (cand > rmax) || (tie_last && (cand == rmax));

  always_comb begin
    if (s1.kind == K_ROW1) begin
      total  = s1.score;
      kstart = '0;
    end else if (take) begin
      total  = cand;
      kstart = s1.start;
    end else begin
      total  = rmax;
      kstart = rstart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmax   <= '0;
      rstart <= '0;
    end else if (s1_go && (s1.kind != K_ROW1)) begin
      rmax   <= total;
      rstart <= kstart;
    end
  end

  // Result register: hold while stalled, take a new beat once free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_go && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.emit) begin
      result.position    <= s1.position;
      result.cluster     <= s1.cluster;
      result.total_score <= total;
      result.best_start  <= kstart + POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else begin
      rec.valid <= s1_go && s1.emit;
    end
    if (s1_go && s1.emit) begin
      rec.position <= s1.position;
      rec.cluster  <= s1.cluster;
      rec.total    <= total;
    end
  end

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import stsdp_pkg::*;

  // Small row store so that a full sequence fits in the run
  localparam int ROWS = 16;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic              cfg_write = 1'b0;
  cfg_reg_t          cfg_index = REG_NUM_CLUSTERS;
  logic [CFG_W-1:0]  cfg_data = '0;

  segment_total_score_dp #(
    .MAX_POSITIONS(ROWS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  item_t   beats_pending[$];
  result_t totals_due[$];
  int      mismatches = 0;
  bit      calm = 1'b0;
  logic    item_took = 1'b0;

  // Mirror of the block: configuration, counters and per-row summaries
  int unsigned              clusters_cfg;
  bit                       tie_last_cfg;
  int unsigned              pos_cnt, clu_cnt, start_cnt, run_start;
  logic signed [SCORE_W-1:0] run_max;
  bit                       seq_full;
  logic signed [SCORE_W-1:0] best_tot[ROWS];
  logic signed [SCORE_W-1:0] second_tot[ROWS];
  logic [CLU_W-1:0]          best_clu[ROWS];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic signed [SCORE_W-1:0] sat_sum(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(SAT_HI)) return SAT_HI;
    if (s < longint'(SAT_LO)) return SAT_LO;
    return s[SCORE_W-1:0];
  endfunction

  function automatic void clear_sequence();
    run_max = '0;
    run_start = 0;
    pos_cnt = 1;
    clu_cnt = 0;
    start_cnt = 0;
    seq_full = 1'b0;
    best_tot[0] = '0;
    second_tot[0] = '0;
    best_clu[0] = '0;
  endfunction

  // Advance the dynamic program by one score beat; queue the total it closes, if any
  function automatic void dp_take(input item_t it);
    int unsigned               nc, k, r;
    logic signed [SCORE_W-1:0] cand, other, total;
    int unsigned               kbest;
    result_t                   due;
    nc = (clusters_cfg == 0) ? 1 : (clusters_cfg > MAX_CLUSTERS ? MAX_CLUSTERS : clusters_cfg);
    if (it.start_sequence) clear_sequence();
    if (seq_full) return;
    if (pos_cnt <= 1) begin
      total = it.score;
      kbest = 0;
    end else begin
      k = start_cnt;
      if (k == 0) begin
        cand = it.score;
      end else if (nc <= 1) begin
        // no other cluster to come from
        cand = SAT_LO;
      end else begin
        r = (k - 1) % ROWS;
        other = (best_clu[r] == clu_cnt[CLU_W-1:0]) ? second_tot[r] : best_tot[r];
        cand = sat_sum(other, it.score);
      end
      if (k == 0 || cand > run_max || (tie_last_cfg && cand == run_max)) begin
        run_max = cand;
        run_start = k;
      end
      if (k + 1 < pos_cnt - 1) begin
        start_cnt = k + 1;
        return;
      end
      total = run_max;
      kbest = run_start;
    end
    r = pos_cnt % ROWS;
    if (clu_cnt == 0) begin
      best_tot[r] = total;
      second_tot[r] = SAT_LO;
      best_clu[r] = '0;
    end else if (total > best_tot[r]) begin
      second_tot[r] = best_tot[r];
      best_tot[r] = total;
      best_clu[r] = clu_cnt[CLU_W-1:0];
    end else if (total > second_tot[r]) begin
      second_tot[r] = total;
    end
    due.position = pos_cnt[POS_BITS-1:0];
    due.cluster = clu_cnt[CLU_W-1:0];
    due.total_score = total;
    due.best_start = POS_BITS'(kbest + 1);
    totals_due.push_back(due);
    start_cnt = 0;
    if (clu_cnt + 1 >= nc) begin
      clu_cnt = 0;
      pos_cnt++;
      if (pos_cnt >= ROWS) seq_full = 1'b1;
    end else begin
      clu_cnt++;
    end
  endfunction

  // Monitor: track config writes, check result beats, predict from accepted score beats
  always @(posedge clk) begin : watch
    result_t want;
    item_took <= item_valid && !item_stall;
    if (rst) begin
      clusters_cfg = 2;
      tie_last_cfg = 1'b1;
      clear_sequence();
      totals_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NUM_CLUSTERS: clusters_cfg = cfg_data;
          REG_TIE_LAST:     tie_last_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (totals_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result position %0d cluster %0d",
                                    result.position, result.cluster));
        end else begin
          want = totals_due.pop_front();
          if (result.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d",
                                      result.position, want.position));
          if (result.cluster !== want.cluster)
            report_mismatch($sformatf("cluster %0d, want %0d (position %0d)",
                                      result.cluster, want.cluster, want.position));
          if (result.total_score !== want.total_score)
            report_mismatch($sformatf("total_score %0d, want %0d (position %0d cluster %0d)",
                                      result.total_score, want.total_score,
                                      want.position, want.cluster));
          if (result.best_start !== want.best_start)
            report_mismatch($sformatf("best_start %0d, want %0d (position %0d cluster %0d)",
                                      result.best_start, want.best_start,
                                      want.position, want.cluster));
        end
      end
      if (item_valid && !item_stall) dp_take(item);
    end
  end

  // Driver: hold a stalled beat, otherwise pull the next one unless idling
  always @(negedge clk) begin
    result_stall <= !calm && ($urandom_range(99) < 27);
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_took) begin
      if (beats_pending.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
        item <= beats_pending.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  task automatic queue_beat(input logic signed [SCORE_W-1:0] s, input logic ss);
    item_t b;
    b.score = s;
    b.start_sequence = ss;
    beats_pending.push_back(b);
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(9))
      0:       return SAT_HI;
      1:       return SAT_LO;
      2:       return '0;
      3, 4:    return int'($urandom_range(4)) - 2;
      5:       return SAT_HI - int'($urandom_range(3));
      6:       return SAT_LO + int'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  // Whole or cut-short sequences of random rows, with the odd stray restart
  task automatic queue_sequences(input int target, input int nc, input int max_rows);
    int added, rows, n, j;
    added = 0;
    while (added < target) begin
      rows = $urandom_range(max_rows, 2);
      n = nc * (1 + rows * (rows - 1) / 2);
      if ($urandom_range(99) < 20) n = $urandom_range(n, 1);
      for (j = 0; j < n; j++)
        queue_beat(pick_score(), j == 0 || $urandom_range(99) < 2);
      added += n;
    end
  endtask

  // Run every row up to the last one, then feed beats that must be dropped
  task automatic queue_full_sequence(input int nc);
    int j;
    for (j = 0; j < nc * (1 + (ROWS - 1) * (ROWS - 2) / 2); j++)
      queue_beat(pick_score(), j == 0);
    for (j = 0; j < 6; j++)
      queue_beat(pick_score(), 1'b0);
  endtask

  task automatic wait_idle();
    while (beats_pending.size() != 0 || item_valid || totals_due.size() != 0)
      @(posedge clk);
    // let a beat with no result clear the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input int unsigned nc, input int unsigned tie);
    wait_idle();
    write_reg(REG_NUM_CLUSTERS, nc);
    write_reg(REG_TIE_LAST, tie);
  endtask

  initial begin : run_limit
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin : sequencer
    int j;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: two clusters, ties to the last start; no restart on the first beat
    queue_beat(SAT_HI, 1'b0);
    queue_beat(SAT_LO, 1'b0);
    queue_beat('0, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(5, 1'b0);
    queue_beat(5, 1'b0);
    queue_beat(SAT_LO, 1'b0);
    queue_beat(SAT_HI, 1'b0);
    queue_beat(SAT_LO, 1'b0);
    queue_beat(SAT_LO, 1'b0);
    queue_beat(SAT_HI, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(1, 1'b0);
    queue_beat(SAT_HI, 1'b0);

    // Single cluster: later starts can only give the most negative total
    set_config(1, 0);
    queue_beat(-7, 1'b1);
    queue_beat(3, 1'b0);
    queue_beat(3, 1'b0);
    queue_beat(SAT_HI, 1'b0);

    // Ties going to the first start
    set_config(2, 0);
    queue_beat(1, 1'b1);
    queue_beat(2, 1'b0);
    queue_beat('0, 1'b0);
    queue_beat('0, 1'b0);
    queue_beat(6, 1'b0);
    queue_beat(5, 1'b0);
    queue_beat(-3, 1'b0);
    queue_beat(-4, 1'b0);

    set_config(3, 1);
    queue_sequences(120, 3, 6);

    // Long stretch with no idling on either side
    set_config(16, 0);
    calm = 1'b1;
    queue_sequences(150, 16, 4);
    wait_idle();
    calm = 1'b0;

    // Zero clusters counts as one
    set_config(0, 1);
    queue_full_sequence(1);

    // Above the maximum counts as the maximum
    set_config(31, 1);
    queue_sequences(100, 16, 3);

    // Lower the count while a row is part done
    set_config(4, 0);
    for (j = 0; j < 12; j++)
      queue_beat(pick_score(), j == 0);
    set_config(2, 0);
    for (j = 0; j < 30; j++)
      queue_beat(pick_score(), 1'b0);
    queue_sequences(100, 2, 7);

    set_config(2, 1);
    queue_full_sequence(2);

    set_config(1, 0);
    queue_sequences(80, 1, 9);

    set_config(5, 1);
    queue_sequences(100, 5, 5);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
